### rtl/coin_change_way_counter_core_defines.svh
// Assertion macros for the coin change way counter checker.
// Used by ccwc_checker.sv; no other dependencies.
`ifndef COIN_CHANGE_WAY_COUNTER_CORE_DEFINES_SVH
`define COIN_CHANGE_WAY_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define CCWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define CCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ccwc_pkg.sv
// Shared types, constants and the microcode ROM of the coin change way counter.
// No dependencies; imported by coin_change_way_counter_core.
`timescale 1ns / 1ps
`default_nettype none

package ccwc_pkg;

    localparam int COIN_W = 10;
    localparam int TGT_W  = 10;
    localparam int WAY_W  = 32;
    localparam int PC_W   = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic {
        REG_TARGET = 1'b0,
        REG_MODE   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        AOP_HOLD,
        AOP_ZERO,
        AOP_COIN,
        AOP_STEP
    } aop_t;

    typedef enum logic [1:0] {
        KOP_HOLD,
        KOP_ZERO,
        KOP_INC
    } kop_t;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_CLEAR,
        MOP_READ,
        MOP_WRITE,
        MOP_READ_GOAL
    } mop_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_START,
        JC_A_MORE,
        JC_PERM,
        JC_K_END,
        JC_SKIP,
        JC_OUT_BUSY
    } jcond_t;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t ST_IDLE    = 5'd0;
    localparam pc_t ST_INIT    = 5'd1;
    localparam pc_t ST_CLEAR   = 5'd2;
    localparam pc_t ST_MODE    = 5'd3;
    localparam pc_t ST_C_KCHK  = 5'd4;
    localparam pc_t ST_C_LOAD  = 5'd5;
    localparam pc_t ST_C_RD    = 5'd6;
    localparam pc_t ST_C_WR    = 5'd7;
    localparam pc_t ST_C_NEXTK = 5'd8;
    localparam pc_t ST_P_INIT  = 5'd9;
    localparam pc_t ST_P_KCHK  = 5'd10;
    localparam pc_t ST_P_RD    = 5'd11;
    localparam pc_t ST_P_WR    = 5'd12;
    localparam pc_t ST_P_NEXTA = 5'd13;
    localparam pc_t ST_DONE    = 5'd14;
    localparam pc_t ST_WAIT    = 5'd15;
    localparam pc_t ST_OUT     = 5'd16;

    typedef struct packed {
        logic   accept;
        logic   goal_load;
        logic   out_load;
        aop_t   aop;
        kop_t   kop;
        mop_t   mop;
        jcond_t jc;
        pc_t    tgt;
    } ctl_word_t;

    // Control store: a step falls through to the next one unless its jump is taken.
    function automatic ctl_word_t ucode_rom(input pc_t pc);
        ctl_word_t w;
        w = '{accept: 1'b0, goal_load: 1'b0, out_load: 1'b0, aop: AOP_HOLD,
              kop: KOP_HOLD, mop: MOP_NONE, jc: JC_NONE, tgt: ST_IDLE};
        case (pc)
            ST_IDLE: begin
                w.accept = 1'b1;
                w.jc     = JC_NO_START;
                w.tgt    = ST_IDLE;
            end
            ST_INIT: begin
                w.goal_load = 1'b1;
                w.aop       = AOP_ZERO;
                w.kop       = KOP_ZERO;
            end
            ST_CLEAR: begin
                w.mop = MOP_CLEAR;
                w.aop = AOP_STEP;
                w.jc  = JC_A_MORE;
                w.tgt = ST_CLEAR;
            end
            ST_MODE: begin
                w.jc  = JC_PERM;
                w.tgt = ST_P_INIT;
            end
            ST_C_KCHK: begin
                w.jc  = JC_K_END;
                w.tgt = ST_DONE;
            end
            ST_C_LOAD: begin
                w.aop = AOP_COIN;
                w.jc  = JC_SKIP;
                w.tgt = ST_C_NEXTK;
            end
            ST_C_RD: begin
                w.mop = MOP_READ;
            end
            ST_C_WR: begin
                w.mop = MOP_WRITE;
                w.aop = AOP_STEP;
                w.jc  = JC_A_MORE;
                w.tgt = ST_C_RD;
            end
            ST_C_NEXTK: begin
                w.kop = KOP_INC;
                w.jc  = JC_ALWAYS;
                w.tgt = ST_C_KCHK;
            end
            ST_P_INIT: begin
                w.aop = AOP_ZERO;
                w.kop = KOP_ZERO;
            end
            ST_P_KCHK: begin
                w.jc  = JC_K_END;
                w.tgt = ST_P_NEXTA;
            end
            ST_P_RD: begin
                w.mop = MOP_READ;
            end
            ST_P_WR: begin
                w.mop = MOP_WRITE;
                w.kop = KOP_INC;
                w.jc  = JC_ALWAYS;
                w.tgt = ST_P_KCHK;
            end
            ST_P_NEXTA: begin
                w.kop = KOP_ZERO;
                w.aop = AOP_STEP;
                w.jc  = JC_A_MORE;
                w.tgt = ST_P_KCHK;
            end
            ST_DONE: begin
                w.mop = MOP_READ_GOAL;
            end
            ST_WAIT: begin
                w.jc  = JC_OUT_BUSY;
                w.tgt = ST_WAIT;
            end
            ST_OUT: begin
                w.out_load = 1'b1;
                w.jc       = JC_ALWAYS;
                w.tgt      = ST_IDLE;
            end
            default: begin
                w.jc  = JC_ALWAYS;
                w.tgt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/coin_change_way_counter_core.sv
// Coin change way counter: coins are taken one per cycle while idle; the last coin
// starts a job. A job clears the way table up to g = saturated target, then adds up
// the ways per coin (combination) or per amount over all n stored coins (permutation);
// its result is held back while an earlier result still waits for m_ready.
// One job at a time; coins of the next job are accepted while a result waits.
// Reset (aresetn low, synchronous) clears the sequencer, coin count, flags and config registers.
`timescale 1ns / 1ps
`default_nettype none

module coin_change_way_counter_core #(
    parameter int MAX_AMOUNT = 1023,
    parameter int MAX_COINS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ccwc_pkg::COIN_W-1:0]   s_coin_value,
    input  wire logic                          s_last_coin,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ccwc_pkg::WAY_W-1:0]         m_way_count,
    output logic                               m_coin_overflow,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ccwc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ccwc_pkg::APB_DW-1:0]   pwdata,
    output logic [ccwc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import ccwc_pkg::*;

    localparam int AMT_W = $clog2(MAX_AMOUNT + 1);
    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam int IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CMP_W = (AMT_W > COIN_W) ? AMT_W : COIN_W;

    pc_t                pc_reg, pc_next;
    ctl_word_t          ctl;
    logic               jump;

    logic [TGT_W-1:0]   tgt_reg;
    logic               mode_reg;
    logic [AMT_W-1:0]   goal_reg, goal_next;
    logic [AMT_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;

    logic [COIN_W-1:0]  coin_mem [MAX_COINS];
    logic [COIN_W-1:0]  coin_rd_reg;
    logic [WAY_W-1:0]   way_mem [DEPTH];
    logic [WAY_W-1:0]   rd_a_reg, rd_b_reg;

    logic               m_valid_reg;
    logic [WAY_W-1:0]   way_reg;
    logic               ovf_out_reg;

    logic               in_fire, cfg_wr, store_room;
    logic               k_lt, coin_ok, coin_skip, a_more, out_busy;
    logic [CMP_W-1:0]   coin_ext, a_ext, goal_ext, diff_ext;
    logic [AMT_W-1:0]   b_addr, rd_a_addr;
    logic               wr_en, rd_en;
    logic [WAY_W-1:0]   wr_data;

    assign ctl     = ucode_rom(pc_reg);
    assign s_ready = ctl.accept;
    assign in_fire = s_valid & s_ready;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_way_count     = way_reg;
    assign m_coin_overflow = ovf_out_reg;

    assign store_room = cnt_reg < CNT_W'(MAX_COINS);
    assign k_lt       = k_reg < cnt_reg;
    assign coin_ext   = CMP_W'(coin_rd_reg);
    assign a_ext      = CMP_W'(a_reg);
    assign goal_ext   = CMP_W'(goal_reg);
    assign diff_ext   = a_ext - coin_ext;
    assign coin_ok    = k_lt && (coin_rd_reg != '0) && (coin_ext <= a_ext);
    assign coin_skip  = (coin_rd_reg == '0) || (coin_ext > goal_ext);
    assign a_more     = a_reg != goal_reg;
    assign out_busy   = m_valid_reg & ~m_ready;

    // Out-of-reach coin slots read address zero; their data is masked anyway.
    assign b_addr    = coin_ok ? diff_ext[AMT_W-1:0] : '0;
    assign rd_a_addr = (ctl.mop == MOP_READ_GOAL) ? goal_reg : a_reg;
    assign rd_en     = (ctl.mop == MOP_READ) || (ctl.mop == MOP_READ_GOAL);
    assign wr_en     = (ctl.mop == MOP_CLEAR) || (ctl.mop == MOP_WRITE);

    always_comb begin
        if (ctl.mop == MOP_CLEAR) begin
            wr_data = (a_reg == '0) ? WAY_W'(1) : '0;
        end else begin
            wr_data = rd_a_reg + (coin_ok ? rd_b_reg : '0);
        end
    end

    always_comb begin
        case (ctl.jc)
            JC_NONE:     jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_START: jump = ~(in_fire & s_last_coin);
            JC_A_MORE:   jump = a_more;
            JC_PERM:     jump = mode_reg;
            JC_K_END:    jump = ~k_lt;
            JC_SKIP:     jump = coin_skip;
            JC_OUT_BUSY: jump = out_busy;
            default:     jump = 1'b0;
        endcase
        pc_next = jump ? ctl.tgt : pc_reg + PC_W'(1);
    end

    always_comb begin
        case (ctl.aop)
            AOP_HOLD: a_next = a_reg;
            AOP_ZERO: a_next = '0;
            AOP_COIN: a_next = coin_ext[AMT_W-1:0];
            AOP_STEP: a_next = jump ? a_reg + AMT_W'(1) : a_reg;
            default:  a_next = a_reg;
        endcase
        case (ctl.kop)
            KOP_HOLD: k_next = k_reg;
            KOP_ZERO: k_next = '0;
            KOP_INC:  k_next = k_reg + CNT_W'(1);
            default:  k_next = k_reg;
        endcase
    end

    // Saturate the target to the table size when the job starts.
    always_comb begin
        goal_next = goal_reg;
        if (ctl.goal_load) begin
            if (32'(tgt_reg) > 32'(MAX_AMOUNT)) begin
                goal_next = AMT_W'(MAX_AMOUNT);
            end else begin
                goal_next = AMT_W'(tgt_reg);
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (in_fire) begin
            if (store_room) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (ctl.out_load) begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= ST_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            tgt_reg     <= '0;
            mode_reg    <= 1'b0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                case (reg_idx_t'(paddr[2]))
                    REG_TARGET: tgt_reg  <= pwdata[TGT_W-1:0];
                    REG_MODE:   mode_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        goal_reg <= goal_next;
        a_reg    <= a_next;
        k_reg    <= k_next;
        if (ctl.out_load) begin
            way_reg     <= rd_a_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // Coin store: one write port from the input, one registered read port at k.
    always_ff @(posedge aclk) begin
        if (in_fire && store_room) begin
            coin_mem[cnt_reg[IDX_W-1:0]] <= s_coin_value;
        end
        coin_rd_reg <= coin_mem[k_reg[IDX_W-1:0]];
    end

    // Way table: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            way_mem[a_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= way_mem[rd_a_addr];
            rd_b_reg <= way_mem[b_addr];
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_TARGET: prdata = APB_DW'(tgt_reg);
            REG_MODE:   prdata = APB_DW'(mode_reg);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ccwc_checker.sv
// Port-level checker for the coin change way counter, bound to the top level.
// Depends on coin_change_way_counter_core_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "coin_change_way_counter_core_defines.svh"

module ccwc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_last_coin,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_way_count,
    input wire logic        m_coin_overflow
);

    // Hold a stalled result.
    `CCWC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_way_count) && $stable(m_coin_overflow), "result changed while stalled")
    // Drop input ready once the closing coin starts a job.
    `CCWC_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last_coin, !s_ready, "input still ready after closing coin")
    // A job never finishes in the cycle after it starts.
    `CCWC_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && s_last_coin && !m_valid, !m_valid, "result appeared right after closing coin")
    // A new result shows up only when the block is back to taking coins.
    `CCWC_ASSERT_NOW(a_idle_on_result, $rose(m_valid), s_ready, "new result while input not ready")

endmodule

bind coin_change_way_counter_core ccwc_checker u_ccwc_checker (.*);

`default_nettype wire
